// File: rtl/relay_bank_delay_timer_controller_core_defines.svh
// assertion helpers for the checker module
// each macro expects clk to exist in the using scope; the reset-gated ones also expect arst_n
`ifndef RELAY_BANK_DELAY_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define RELAY_BANK_DELAY_TIMER_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define RBDT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbdt check failed");

// next-cycle implication
`define RBDT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbdt check failed");

// check without reset gating, for reset release behavior
`define RBDT_ASSERT_RAW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("rbdt check failed");

`endif

// File: rtl/rbdt_pkg.sv
`default_nettype none

package rbdt_pkg;

	localparam int MaxChannels = 8;
	localparam int ChIdxW      = 3;
	localparam int SubW        = 16;
	localparam int SecW        = 20;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_SET   = 2'd2,
		CMD_GROUP = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD      = 2'd1,
		ST_NOT_HERE = 2'd2
	} status_t;

	// per-item control from the decoder to every channel
	typedef struct packed {
		logic                   tick;
		logic [MaxChannels-1:0] upd_mask;
		logic [MaxChannels-1:0] on_mask;
		logic                   load;
		logic [SecW-1:0]        load_secs;
		status_t                status;
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/rbdt_cmd_decode.sv
`default_nettype none

module rbdt_cmd_decode #(
	parameter int CHANNEL_COUNT = 8
) (
	input  rbdt_pkg::cmd_e_t        cmd,
	input  logic [7:0]              target_address,
	input  logic [7:0]              channel_select,
	input  logic [7:0]              new_state,
	input  logic [rbdt_pkg::SecW-1:0] delay_seconds,
	input  logic [7:0]              own_address,
	output rbdt_pkg::ctl_t          ctl
);

	localparam int MaskInt = (1 << CHANNEL_COUNT) - 1;
	localparam logic [7:0] ChanMask = 8'(MaskInt);
	localparam logic [7:0] ChLimit  = 8'(CHANNEL_COUNT);

	logic [7:0] one_hot;

	assign one_hot = 8'(1) << channel_select[rbdt_pkg::ChIdxW-1:0];

	// classify the item and build the channel update masks
	always_comb begin
		ctl           = '0;
		ctl.status    = rbdt_pkg::ST_OK;
		ctl.load_secs = delay_seconds;
		unique case (cmd)
			rbdt_pkg::CMD_TICK: begin
				ctl.tick = 1'b1;
			end
			rbdt_pkg::CMD_QUERY: begin
				if (target_address != own_address) begin
					ctl.status = rbdt_pkg::ST_NOT_HERE;
				end
			end
			rbdt_pkg::CMD_SET: begin
				if (target_address != own_address) begin
					ctl.status = rbdt_pkg::ST_NOT_HERE;
				end else if (channel_select >= ChLimit || new_state > 8'd1) begin
					ctl.status = rbdt_pkg::ST_BAD;
				end else begin
					ctl.upd_mask = one_hot;
					ctl.on_mask  = new_state[0] ? one_hot : 8'd0;
					ctl.load     = (delay_seconds != '0);
				end
			end
			rbdt_pkg::CMD_GROUP: begin
				if (target_address != own_address) begin
					ctl.status = rbdt_pkg::ST_NOT_HERE;
				end else if (channel_select == 8'd0) begin
					ctl.status = rbdt_pkg::ST_BAD;
				end else begin
					ctl.upd_mask = channel_select & ChanMask;
					ctl.on_mask  = new_state;
					ctl.load     = (delay_seconds != '0);
				end
			end
			default: begin
				ctl.status = rbdt_pkg::ST_BAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/rbdt_channel.sv
`default_nettype none

module rbdt_channel #(
	parameter int CH_IDX           = 0,
	parameter int TICKS_PER_SECOND = 100
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  rbdt_pkg::ctl_t ctl,
	output logic           relay_d,
	output logic           active_d
);

	localparam logic [rbdt_pkg::SubW-1:0] SubReload = rbdt_pkg::SubW'(TICKS_PER_SECOND);

	logic                      relay_q;
	logic                      active_q;
	logic [rbdt_pkg::SubW-1:0] sub_q;
	logic [rbdt_pkg::SecW-1:0] sec_q;
	logic [rbdt_pkg::SubW-1:0] sub_d;
	logic [rbdt_pkg::SecW-1:0] sec_d;
	logic [rbdt_pkg::SubW-1:0] sub_dec;
	logic [rbdt_pkg::SecW-1:0] sec_dec;

	assign sub_dec = sub_q - 1'b1;
	assign sec_dec = sec_q - 1'b1;

	// next channel state for the current item
	always_comb begin
		relay_d  = relay_q;
		active_d = active_q;
		sub_d    = sub_q;
		sec_d    = sec_q;
		if (ctl.tick) begin
			if (active_q) begin
				sub_d = sub_dec;
				if (sub_dec == '0) begin
					sec_d = sec_dec;
					if (sec_dec != '0) begin
						sub_d = SubReload;
					end else begin
						relay_d  = 1'b0;
						active_d = 1'b0;
					end
				end
			end
		end else if (ctl.upd_mask[CH_IDX]) begin
			relay_d = ctl.on_mask[CH_IDX];
			if (ctl.load) begin
				sec_d    = ctl.load_secs;
				sub_d    = SubReload;
				active_d = 1'b1;
			end
		end
	end

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (advance) begin
			relay_q  <= relay_d;
			active_q <= active_d;
		end
	end

	// counters, only read while active
	always_ff @(posedge clk) begin
		if (advance) begin
			sub_q <= sub_d;
			sec_q <= sec_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/relay_bank_delay_timer_controller_core.sv
// an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle unless stalled; per-channel update is one pass
// back-pressure on the result side stalls the input register only once both are full
// reset: relay bits, timer active bits, own address and all valid flags clear
// timer counters are not reset; they are loaded whenever a timer starts
`default_nettype none

module relay_bank_delay_timer_controller_core #(
	parameter int CHANNEL_COUNT    = 8,
	parameter int TICKS_PER_SECOND = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,     // own_address
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,         // target_address, channel_select, new_state, delay_seconds
	input  logic [1:0]  s_tuser,         // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata          // relay_outputs, timers_running, status
);

	logic                      valid_s1;
	rbdt_pkg::cmd_e_t          cmd_s1;
	logic [7:0]                addr_s1;
	logic [7:0]                sel_s1;
	logic [7:0]                nst_s1;
	logic [rbdt_pkg::SecW-1:0] delay_s1;
	logic [7:0]                own_addr_q;
	logic                      out_valid_q;
	logic [7:0]                relay_out_q;
	logic [7:0]                timers_out_q;
	rbdt_pkg::status_t         status_out_q;
	logic                      advance;
	rbdt_pkg::ctl_t            ctl;
	logic [7:0]                relay_next;
	logic [7:0]                active_next;
	logic [CHANNEL_COUNT-1:0]  relay_bit;
	logic [CHANNEL_COUNT-1:0]  active_bit;

	// handshake: the item in the input register moves on when the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= 8'd0;
		end else if (cfg_wr_en) begin
			own_addr_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= rbdt_pkg::cmd_e_t'(s_tuser);
			addr_s1  <= s_tdata[7:0];
			sel_s1   <= s_tdata[15:8];
			nst_s1   <= s_tdata[23:16];
			delay_s1 <= s_tdata[43:24];
		end
	end

	// command decode
	rbdt_cmd_decode #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_decode (
		.cmd           (cmd_s1),
		.target_address(addr_s1),
		.channel_select(sel_s1),
		.new_state     (nst_s1),
		.delay_seconds (delay_s1),
		.own_address   (own_addr_q),
		.ctl           (ctl)
	);

	// one timer and relay per channel, unused channels read as off
	always_comb begin
		relay_next  = 8'd0;
		active_next = 8'd0;
		for (int i = 0; i < CHANNEL_COUNT; i++) begin
			relay_next[i]  = relay_bit[i];
			active_next[i] = active_bit[i];
		end
	end

	for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_ch
		rbdt_channel #(
			.CH_IDX          (g),
			.TICKS_PER_SECOND(TICKS_PER_SECOND)
		) u_channel (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.ctl     (ctl),
			.relay_d (relay_bit[g]),
			.active_d(active_bit[g])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_out_q  <= relay_next;
			timers_out_q <= active_next;
			status_out_q <= ctl.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, status_out_q, timers_out_q, relay_out_q};

endmodule

`default_nettype wire

// File: rtl/rbdt_checker.sv
`default_nettype none
`include "relay_bank_delay_timer_controller_core_defines.svh"

module rbdt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	logic        have_prev_q;
	logic [15:0] prev_bits_q;
	logic        rejected;

	assign rejected = m_tdata[17:16] != rbdt_pkg::ST_OK;

	// last delivered relay and timer bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_bits_q <= 16'd0;
		end else if (m_tvalid && m_tready) begin
			have_prev_q <= 1'b1;
			prev_bits_q <= m_tdata[15:0];
		end
	end

	// a held result stays put
	`RBDT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a rejected or foreign frame changes no relay or timer
	`RBDT_ASSERT_IMP(a_reject_no_change, m_tvalid && rejected && have_prev_q,
		m_tdata[15:0] == prev_bits_q)

	// input stalls only behind a waiting result
	`RBDT_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid)

	// nothing comes out right after reset release
	`RBDT_ASSERT_RAW(a_reset_quiet, $rose(arst_n), !m_tvalid)

endmodule

bind relay_bank_delay_timer_controller_core rbdt_checker u_rbdt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
